// File: design/nll_pkg.sv
// ----------------------------------------------------------------------------
// Nearest light list package
// Shared types and constants for the nearest light list core.
// ----------------------------------------------------------------------------
package nll_pkg;

  localparam int unsigned PosW  = 16;
  localparam int unsigned ColW  = 8;
  localparam int unsigned RadW  = 16;
  localparam int unsigned DistW = 34;
  localparam int unsigned SlotW = 3;
  localparam int unsigned CntW  = 4;
  localparam int unsigned MaxRes = 8;

  typedef enum logic [1:0] {
    OpAppend  = 2'd0,
    OpInsert  = 2'd1,
    OpRead    = 2'd2,
    OpClosest = 2'd3
  } op_e;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
    logic [ColW-1:0]        red;
    logic [ColW-1:0]        green;
    logic [ColW-1:0]        blue;
    logic [RadW-1:0]        radius;
  } entry_t;

  typedef struct packed {
    logic en;
    logic clr;
  } dist_ctrl_t;

endpackage

// File: design/nll_dist.sv
// ----------------------------------------------------------------------------
// Squared distance unit
// Accumulates one squared axis difference per enabled cycle.
// ----------------------------------------------------------------------------
module nll_dist (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  nll_pkg::dist_ctrl_t                 ctrl_i,
  input  logic signed [nll_pkg::PosW-1:0]     a_i,
  input  logic signed [nll_pkg::PosW-1:0]     b_i,
  output logic [nll_pkg::DistW-1:0]           sum_o
);

  logic signed [nll_pkg::PosW:0]      diff;
  logic signed [2*nll_pkg::PosW+1:0]  sq;
  logic [nll_pkg::DistW-1:0]          base;
  logic [nll_pkg::DistW-1:0]          sum_d;
  logic [nll_pkg::DistW-1:0]          sum_q;

  always_comb begin
    diff  = (nll_pkg::PosW+1)'(a_i) - (nll_pkg::PosW+1)'(b_i);
    sq    = diff * diff;
    base  = ctrl_i.clr ? '0 : sum_q;
    sum_d = base + nll_pkg::DistW'(unsigned'(sq));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.en) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// File: design/nll_store.sv
// ----------------------------------------------------------------------------
// Light entry store
// Register file of light entries, one write and one read port.
// ----------------------------------------------------------------------------
module nll_store #(
  parameter int unsigned LIGHTS = 8,
  parameter int unsigned IW     = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IW-1:0]    waddr_i,
  input  nll_pkg::entry_t  wdata_i,
  input  logic [IW-1:0]    raddr_i,
  output nll_pkg::entry_t  rdata_o
);

  nll_pkg::entry_t mem_q [LIGHTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[raddr_i];

endmodule

// File: design/nearest_light_list_core.sv
// ----------------------------------------------------------------------------
// Nearest light list core
// Bounded list of point lights with append (at the end), insert (ahead of the
// first entry farther from the reference point), read and closest queries.
// ----------------------------------------------------------------------------
// One item at a time. A single squared-distance unit handles one axis per
// cycle, so each distance takes the three axes in turn. Closest scans every
// listed entry, insert scans until it finds its place and then shifts the
// later entries down, and read emits one result per listed entry. A finished
// result waits in the output register while the next item is accepted.
module nearest_light_list_core #(
  parameter int unsigned LIGHTS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        operation_i,
  input  logic [31:0]                       frame_number_i,
  input  logic signed [nll_pkg::PosW-1:0]   light_x_i,
  input  logic signed [nll_pkg::PosW-1:0]   light_y_i,
  input  logic signed [nll_pkg::PosW-1:0]   light_z_i,
  input  logic [nll_pkg::ColW-1:0]          red_i,
  input  logic [nll_pkg::ColW-1:0]          green_i,
  input  logic [nll_pkg::ColW-1:0]          blue_i,
  input  logic [nll_pkg::RadW-1:0]          light_radius_i,
  input  logic signed [nll_pkg::PosW-1:0]   ref_x_i,
  input  logic signed [nll_pkg::PosW-1:0]   ref_y_i,
  input  logic signed [nll_pkg::PosW-1:0]   ref_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              found_o,
  output logic [nll_pkg::SlotW-1:0]         slot_o,
  output logic [nll_pkg::CntW-1:0]          count_o,
  output logic signed [nll_pkg::PosW-1:0]   out_x_o,
  output logic signed [nll_pkg::PosW-1:0]   out_y_o,
  output logic signed [nll_pkg::PosW-1:0]   out_z_o,
  output logic [nll_pkg::ColW-1:0]          out_red_o,
  output logic [nll_pkg::ColW-1:0]          out_green_o,
  output logic [nll_pkg::ColW-1:0]          out_blue_o,
  output logic [nll_pkg::RadW-1:0]          out_radius_o,
  output logic                              last_o
);

  localparam int unsigned CW = $clog2(LIGHTS + 1);
  localparam int unsigned IW = $clog2(LIGHTS);
  localparam int unsigned WW = CW + 4;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DNEW  = 4'd1;
  localparam logic [3:0] S_DSAVE = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_DENT  = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_PUT   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_READ  = 4'd9;

  logic [3:0]                state_q, state_d;
  logic [1:0]                axis_q, axis_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic [CW-1:0]             pos_q, pos_d;
  logic [CW-1:0]             j_q, j_d;
  logic [CW-1:0]             best_idx_q, best_idx_d;
  logic                      have_q, have_d;
  logic [nll_pkg::DistW-1:0] dn_q, dn_d;
  logic [nll_pkg::DistW-1:0] best_q, best_d;
  logic [CW-1:0]             count_q, count_d;
  logic [31:0]               frame_q, frame_d;
  logic                      res_found_q, res_found_d;
  logic [CW-1:0]             res_slot_q, res_slot_d;

  nll_pkg::op_e              op_q;
  nll_pkg::entry_t           item_q;
  logic signed [nll_pkg::PosW-1:0] rx_q, ry_q, rz_q;

  logic                      out_valid_q, out_valid_d;
  logic                      found_q;
  logic [nll_pkg::SlotW-1:0] slot_q;
  logic [nll_pkg::CntW-1:0]  cnt_q;
  nll_pkg::entry_t           oent_q;
  logic                      last_q;

  logic                      acc;
  logic                      out_free;
  logic                      newer;
  logic                      is_add;
  logic [CW-1:0]             cnt_eff;
  logic [CW-1:0]             jm1;
  logic [IW-1:0]             raddr;
  logic                      we;
  logic [IW-1:0]             waddr;
  nll_pkg::entry_t           wdata;
  nll_pkg::entry_t           rdata;
  nll_pkg::dist_ctrl_t       dctl;
  logic signed [nll_pkg::PosW-1:0] da, db;
  logic [nll_pkg::DistW-1:0] dsum;
  logic                      load;
  logic                      load_found;
  logic [CW-1:0]             load_slot;
  logic                      load_entry;
  logic                      load_last;
  logic [WW-1:0]             slot_w;
  logic [WW-1:0]             cnt_w;
  logic [WW-1:0]             idx_w;
  logic                      rd_last;
  nll_pkg::entry_t           ld_ent;

  nll_store #(.LIGHTS(LIGHTS), .IW(IW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  nll_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dctl),
    .a_i    (da),
    .b_i    (db),
    .sum_o  (dsum)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign acc        = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_add     = (nll_pkg::op_e'(operation_i) == nll_pkg::OpAppend) ||
                      (nll_pkg::op_e'(operation_i) == nll_pkg::OpInsert);
  assign newer      = is_add && (frame_q < frame_number_i);
  assign cnt_eff    = newer ? '0 : count_q;
  assign jm1        = j_q - CW'(1);
  assign raddr      = (state_q == S_SHIFT) ? jm1[IW-1:0] : idx_q[IW-1:0];
  assign idx_w      = WW'(idx_q);
  assign rd_last    = ((idx_q + CW'(1)) == count_q) ||
                      (idx_w == WW'(nll_pkg::MaxRes - 1));

  always_comb begin
    da = rdata.x;
    db = rx_q;
    case (axis_q)
      2'd0: begin
        da = (state_q == S_DNEW) ? item_q.x : rdata.x;
        db = rx_q;
      end
      2'd1: begin
        da = (state_q == S_DNEW) ? item_q.y : rdata.y;
        db = ry_q;
      end
      2'd2: begin
        da = (state_q == S_DNEW) ? item_q.z : rdata.z;
        db = rz_q;
      end
      default: begin
        da = rdata.x;
        db = rx_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    j_d         = j_q;
    best_idx_d  = best_idx_q;
    have_d      = have_q;
    dn_d        = dn_q;
    best_d      = best_q;
    count_d     = count_q;
    frame_d     = frame_q;
    res_found_d = res_found_q;
    res_slot_d  = res_slot_q;
    we          = 1'b0;
    waddr       = pos_q[IW-1:0];
    wdata       = item_q;
    dctl        = '0;
    load        = 1'b0;
    load_found  = res_found_q;
    load_slot   = res_slot_q;
    load_entry  = 1'b0;
    load_last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (newer) begin
            frame_d = frame_number_i;
            count_d = '0;
          end
          idx_d      = '0;
          axis_d     = '0;
          have_d     = 1'b0;
          best_idx_d = '0;
          case (nll_pkg::op_e'(operation_i))
            nll_pkg::OpAppend: begin
              pos_d   = cnt_eff;
              state_d = S_PUT;
            end
            nll_pkg::OpInsert: begin
              state_d = S_DNEW;
            end
            nll_pkg::OpRead: begin
              if (count_q == '0) begin
                res_found_d = 1'b0;
                res_slot_d  = '0;
                state_d     = S_EMIT;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_SCAN;
            end
          endcase
        end
      end
      S_DNEW: begin
        dctl.en  = 1'b1;
        dctl.clr = (axis_q == 2'd0);
        axis_d   = axis_q + 2'd1;
        if (axis_q == 2'd2) begin
          axis_d  = '0;
          state_d = S_DSAVE;
        end
      end
      S_DSAVE: begin
        dn_d    = dsum;
        idx_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        axis_d = '0;
        if (idx_q == count_q) begin
          if (op_q == nll_pkg::OpInsert) begin
            pos_d   = idx_q;
            state_d = S_PUT;
          end else begin
            res_found_d = have_q;
            res_slot_d  = best_idx_q;
            state_d     = S_EMIT;
          end
        end else begin
          state_d = S_DENT;
        end
      end
      S_DENT: begin
        dctl.en  = 1'b1;
        dctl.clr = (axis_q == 2'd0);
        axis_d   = axis_q + 2'd1;
        if (axis_q == 2'd2) begin
          axis_d  = '0;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        idx_d   = idx_q + CW'(1);
        state_d = S_SCAN;
        if (op_q == nll_pkg::OpInsert) begin
          if (dn_q < dsum) begin
            idx_d   = idx_q;
            pos_d   = idx_q;
            j_d     = (count_q == CW'(LIGHTS)) ? count_q - CW'(1) : count_q;
            state_d = S_SHIFT;
          end
        end else if (!have_q || (dsum < best_q)) begin
          have_d     = 1'b1;
          best_d     = dsum;
          best_idx_d = idx_q;
        end
      end
      S_SHIFT: begin
        if (j_q == pos_q) begin
          state_d = S_PUT;
        end else begin
          we    = 1'b1;
          waddr = j_q[IW-1:0];
          wdata = rdata;
          j_d   = jm1;
        end
      end
      S_PUT: begin
        state_d = S_EMIT;
        if (pos_q < CW'(LIGHTS)) begin
          we          = 1'b1;
          waddr       = pos_q[IW-1:0];
          wdata       = item_q;
          res_found_d = 1'b1;
          res_slot_d  = pos_q;
          if (count_q < CW'(LIGHTS)) begin
            count_d = count_q + CW'(1);
          end
        end else begin
          res_found_d = 1'b0;
          res_slot_d  = '0;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          load       = 1'b1;
          load_found = 1'b1;
          load_slot  = idx_q;
          load_entry = 1'b1;
          load_last  = rd_last;
          if (rd_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign slot_w      = WW'(load_found ? load_slot : '0);
  assign cnt_w       = WW'(count_q);
  assign ld_ent      = load_entry ? rdata : '0;
  assign out_valid_d = load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      j_q         <= '0;
      best_idx_q  <= '0;
      have_q      <= 1'b0;
      count_q     <= '0;
      frame_q     <= '0;
      res_found_q <= 1'b0;
      res_slot_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      j_q         <= j_d;
      best_idx_q  <= best_idx_d;
      have_q      <= have_d;
      count_q     <= count_d;
      frame_q     <= frame_d;
      res_found_q <= res_found_d;
      res_slot_q  <= res_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dn_q   <= dn_d;
    best_q <= best_d;
    if (acc) begin
      op_q          <= nll_pkg::op_e'(operation_i);
      item_q.x      <= light_x_i;
      item_q.y      <= light_y_i;
      item_q.z      <= light_z_i;
      item_q.red    <= red_i;
      item_q.green  <= green_i;
      item_q.blue   <= blue_i;
      item_q.radius <= light_radius_i;
      rx_q          <= ref_x_i;
      ry_q          <= ref_y_i;
      rz_q          <= ref_z_i;
    end
    if (load) begin
      found_q <= load_found;
      slot_q  <= slot_w[nll_pkg::SlotW-1:0];
      cnt_q   <= cnt_w[nll_pkg::CntW-1:0];
      oent_q  <= ld_ent;
      last_q  <= load_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign slot_o       = slot_q;
  assign count_o      = cnt_q;
  assign out_x_o      = oent_q.x;
  assign out_y_o      = oent_q.y;
  assign out_z_o      = oent_q.z;
  assign out_red_o    = oent_q.red;
  assign out_green_o  = oent_q.green;
  assign out_blue_o   = oent_q.blue;
  assign out_radius_o = oent_q.radius;
  assign last_o       = last_q;

endmodule

// File: design/nll_checker.sv
// ----------------------------------------------------------------------------
// Nearest light list checker
// Port-level assertions on the nearest light list core.
// ----------------------------------------------------------------------------
module nll_port_checker #(
  parameter int unsigned LIGHTS = 8
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            found_o,
  input logic [nll_pkg::SlotW-1:0]       slot_o,
  input logic [nll_pkg::CntW-1:0]        count_o,
  input logic signed [nll_pkg::PosW-1:0] out_x_o,
  input logic [nll_pkg::RadW-1:0]        out_radius_o,
  input logic                            last_o
);

  localparam int unsigned CW = $clog2(LIGHTS + 1);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a second item without a busy cycle");

  a_not_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> slot_o == '0 && out_x_o == '0 && out_radius_o == '0)
    else $error("result without a hit carries a slot or entry data");

  a_multi_is_listed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> found_o)
    else $error("non-final result without a listed entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (CW <= nll_pkg::CntW) |-> count_o <= nll_pkg::CntW'(LIGHTS))
    else $error("count above list size");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_o) && $stable(last_o))
    else $error("stalled result changed");

endmodule

bind nearest_light_list_core nll_port_checker #(.LIGHTS(LIGHTS)) u_nll_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .found_o      (found_o),
  .slot_o       (slot_o),
  .count_o      (count_o),
  .out_x_o      (out_x_o),
  .out_radius_o (out_radius_o),
  .last_o       (last_o)
);

// File: sim/nll_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest light list checker
// Watches the input and result channels of the core, keeps its own copy of
// the light list and frame, predicts the results of every accepted item and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module nll_checker #(
  parameter int unsigned LIGHTS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [1:0]                        operation_i,
  input  logic [31:0]                       frame_number_i,
  input  logic signed [nll_pkg::PosW-1:0]   light_x_i,
  input  logic signed [nll_pkg::PosW-1:0]   light_y_i,
  input  logic signed [nll_pkg::PosW-1:0]   light_z_i,
  input  logic [nll_pkg::ColW-1:0]          red_i,
  input  logic [nll_pkg::ColW-1:0]          green_i,
  input  logic [nll_pkg::ColW-1:0]          blue_i,
  input  logic [nll_pkg::RadW-1:0]          light_radius_i,
  input  logic signed [nll_pkg::PosW-1:0]   ref_x_i,
  input  logic signed [nll_pkg::PosW-1:0]   ref_y_i,
  input  logic signed [nll_pkg::PosW-1:0]   ref_z_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic                              found_i,
  input  logic [nll_pkg::SlotW-1:0]         slot_i,
  input  logic [nll_pkg::CntW-1:0]          count_i,
  input  logic signed [nll_pkg::PosW-1:0]   out_x_i,
  input  logic signed [nll_pkg::PosW-1:0]   out_y_i,
  input  logic signed [nll_pkg::PosW-1:0]   out_z_i,
  input  logic [nll_pkg::ColW-1:0]          out_red_i,
  input  logic [nll_pkg::ColW-1:0]          out_green_i,
  input  logic [nll_pkg::ColW-1:0]          out_blue_i,
  input  logic [nll_pkg::RadW-1:0]          out_radius_i,
  input  logic                              last_i,
  output int                                errors_o,
  output int                                pending_o
);

  typedef struct packed {
    logic                            found;
    logic [nll_pkg::SlotW-1:0]       slot;
    logic [nll_pkg::CntW-1:0]        count;
    logic signed [nll_pkg::PosW-1:0] x;
    logic signed [nll_pkg::PosW-1:0] y;
    logic signed [nll_pkg::PosW-1:0] z;
    logic [nll_pkg::ColW-1:0]        red;
    logic [nll_pkg::ColW-1:0]        green;
    logic [nll_pkg::ColW-1:0]        blue;
    logic [nll_pkg::RadW-1:0]        radius;
    logic                            last;
  } light_result_t;

  nll_pkg::entry_t light_store [LIGHTS];
  int unsigned     held_count;
  logic [31:0]     held_frame;
  light_result_t   results_due [$];

  function automatic logic [63:0] sq_dist(
      input logic signed [nll_pkg::PosW-1:0] ax, ay, az,
      input logic signed [nll_pkg::PosW-1:0] bx, by, bz);
    longint dx;
    longint dy;
    longint dz;
    dx = ax - bx;
    dy = ay - by;
    dz = az - bz;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic string show_result(input light_result_t r);
    return $sformatf({"found=%0d slot=%0d count=%0d pos=(%0d,%0d,%0d) ",
                      "rgb=(%0d,%0d,%0d) radius=%0d last=%0d"},
                     r.found, r.slot, r.count, r.x, r.y, r.z, r.red, r.green, r.blue,
                     r.radius, r.last);
  endfunction

  task automatic push_result(input logic found, input int unsigned slot, input logic listed,
                             input nll_pkg::entry_t e, input logic last);
    light_result_t r;
    r = '0;
    r.found = found;
    r.slot  = found ? slot[nll_pkg::SlotW-1:0] : '0;
    r.count = held_count[nll_pkg::CntW-1:0];
    if (listed) begin
      r.x      = e.x;
      r.y      = e.y;
      r.z      = e.z;
      r.red    = e.red;
      r.green  = e.green;
      r.blue   = e.blue;
      r.radius = e.radius;
    end
    r.last = last;
    results_due.push_back(r);
  endtask

  task automatic predict_light_step();
    nll_pkg::op_e    op;
    nll_pkg::entry_t fresh;
    logic [63:0]     dn;
    logic [63:0]     d;
    logic [63:0]     bd;
    logic            placed;
    logic            have;
    int unsigned     pos;
    int unsigned     top;
    int unsigned     n;
    int unsigned     best;
    int unsigned     i;
    op           = nll_pkg::op_e'(operation_i);
    fresh.x      = light_x_i;
    fresh.y      = light_y_i;
    fresh.z      = light_z_i;
    fresh.red    = red_i;
    fresh.green  = green_i;
    fresh.blue   = blue_i;
    fresh.radius = light_radius_i;
    if ((op == nll_pkg::OpAppend || op == nll_pkg::OpInsert) &&
        held_frame < frame_number_i) begin
      held_count = 0;
      held_frame = frame_number_i;
    end
    case (op)
      nll_pkg::OpAppend: begin
        if (held_count < LIGHTS) begin
          pos = held_count;
          light_store[pos] = fresh;
          held_count++;
          push_result(1'b1, pos, 1'b0, fresh, 1'b1);
        end else begin
          push_result(1'b0, 0, 1'b0, fresh, 1'b1);
        end
      end
      nll_pkg::OpInsert: begin
        dn = sq_dist(fresh.x, fresh.y, fresh.z, ref_x_i, ref_y_i, ref_z_i);
        pos = held_count;
        placed = 1'b0;
        for (i = 0; i < held_count; i++) begin
          if (!placed && dn < sq_dist(light_store[i].x, light_store[i].y, light_store[i].z,
                                      ref_x_i, ref_y_i, ref_z_i)) begin
            pos = i;
            placed = 1'b1;
          end
        end
        if (pos < LIGHTS) begin
          top = (held_count == LIGHTS) ? LIGHTS - 1 : held_count;
          for (i = top; i > pos; i--) light_store[i] = light_store[i-1];
          light_store[pos] = fresh;
          if (held_count < LIGHTS) held_count++;
          push_result(1'b1, pos, 1'b0, fresh, 1'b1);
        end else begin
          push_result(1'b0, 0, 1'b0, fresh, 1'b1);
        end
      end
      nll_pkg::OpRead: begin
        n = (held_count < nll_pkg::MaxRes) ? held_count : nll_pkg::MaxRes;
        if (n == 0) begin
          push_result(1'b0, 0, 1'b0, fresh, 1'b1);
        end else begin
          for (i = 0; i < n; i++) push_result(1'b1, i, 1'b1, light_store[i], i + 1 == n);
        end
      end
      default: begin
        have = 1'b0;
        best = 0;
        bd = '0;
        for (i = 0; i < held_count; i++) begin
          d = sq_dist(light_store[i].x, light_store[i].y, light_store[i].z,
                      ref_x_i, ref_y_i, ref_z_i);
          if (!have || d < bd) begin
            have = 1'b1;
            bd = d;
            best = i;
          end
        end
        push_result(have, best, 1'b0, fresh, 1'b1);
      end
    endcase
  endtask

  task automatic check_result();
    light_result_t seen;
    light_result_t want;
    seen = {found_i, slot_i, count_i, out_x_i, out_y_i, out_z_i, out_red_i, out_green_i,
            out_blue_i, out_radius_i, last_i};
    if (results_due.size() == 0) begin
      errors_o++;
      $display("%0t: result with no item pending\n  expected none\n  actual   %s",
               $time, show_result(seen));
    end else begin
      want = results_due.pop_front();
      if (seen !== want) begin
        errors_o++;
        $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                 $time, show_result(want), show_result(seen));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      held_frame = '0;
      results_due.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) predict_light_step();
      pending_o = results_due.size();
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest light list testbench
// Drives the core with a directed set of list operations and then random
// frames of appends, inserts, reads and closest queries under several idle
// and stall patterns, including one long result hold-off. A checker beside
// the core predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned LIGHTS = 8;

  typedef struct {
    nll_pkg::op_e                    op;
    logic [31:0]                     frame;
    logic signed [nll_pkg::PosW-1:0] lx;
    logic signed [nll_pkg::PosW-1:0] ly;
    logic signed [nll_pkg::PosW-1:0] lz;
    logic [nll_pkg::ColW-1:0]        r;
    logic [nll_pkg::ColW-1:0]        g;
    logic [nll_pkg::ColW-1:0]        b;
    logic [nll_pkg::RadW-1:0]        rad;
    logic signed [nll_pkg::PosW-1:0] rx;
    logic signed [nll_pkg::PosW-1:0] ry;
    logic signed [nll_pkg::PosW-1:0] rz;
  } light_item_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [1:0]                      operation;
  logic [31:0]                     frame_number;
  logic signed [nll_pkg::PosW-1:0] light_x;
  logic signed [nll_pkg::PosW-1:0] light_y;
  logic signed [nll_pkg::PosW-1:0] light_z;
  logic [nll_pkg::ColW-1:0]        red;
  logic [nll_pkg::ColW-1:0]        green;
  logic [nll_pkg::ColW-1:0]        blue;
  logic [nll_pkg::RadW-1:0]        light_radius;
  logic signed [nll_pkg::PosW-1:0] ref_x;
  logic signed [nll_pkg::PosW-1:0] ref_y;
  logic signed [nll_pkg::PosW-1:0] ref_z;
  logic                            out_valid;
  logic                            out_stall;
  logic                            found;
  logic [nll_pkg::SlotW-1:0]       slot;
  logic [nll_pkg::CntW-1:0]        count;
  logic signed [nll_pkg::PosW-1:0] out_x;
  logic signed [nll_pkg::PosW-1:0] out_y;
  logic signed [nll_pkg::PosW-1:0] out_z;
  logic [nll_pkg::ColW-1:0]        out_red;
  logic [nll_pkg::ColW-1:0]        out_green;
  logic [nll_pkg::ColW-1:0]        out_blue;
  logic [nll_pkg::RadW-1:0]        out_radius;
  logic                            last;

  int                              errors;
  int                              pending;
  int                              send_idle_pct;
  int                              stall_pct;
  int                              hold_req_cnt;
  logic [31:0]                     cur_frame;
  logic signed [nll_pkg::PosW-1:0] cur_ref [3];
  int                              idle_plan [4] = '{0, 55, 0, 29};
  int                              stall_plan [4] = '{0, 0, 55, 29};

  nearest_light_list_core #(
    .LIGHTS(LIGHTS)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .frame_number_i (frame_number),
    .light_x_i      (light_x),
    .light_y_i      (light_y),
    .light_z_i      (light_z),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .light_radius_i (light_radius),
    .ref_x_i        (ref_x),
    .ref_y_i        (ref_y),
    .ref_z_i        (ref_z),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .found_o        (found),
    .slot_o         (slot),
    .count_o        (count),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .out_z_o        (out_z),
    .out_red_o      (out_red),
    .out_green_o    (out_green),
    .out_blue_o     (out_blue),
    .out_radius_o   (out_radius),
    .last_o         (last)
  );

  nll_checker #(
    .LIGHTS(LIGHTS)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .operation_i    (operation),
    .frame_number_i (frame_number),
    .light_x_i      (light_x),
    .light_y_i      (light_y),
    .light_z_i      (light_z),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .light_radius_i (light_radius),
    .ref_x_i        (ref_x),
    .ref_y_i        (ref_y),
    .ref_z_i        (ref_z),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .found_i        (found),
    .slot_i         (slot),
    .count_i        (count),
    .out_x_i        (out_x),
    .out_y_i        (out_y),
    .out_z_i        (out_z),
    .out_red_i      (out_red),
    .out_green_i    (out_green),
    .out_blue_i     (out_blue),
    .out_radius_i   (out_radius),
    .last_i         (last),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // hold off results for a long stretch on request, else stall at random
  initial begin
    int hold_ack;
    hold_ack = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req_cnt != hold_ack) begin
        hold_ack = hold_req_cnt;
        repeat (300) begin
          out_stall = 1'b1;
          @(negedge clk);
        end
      end
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  function automatic light_item_t light_op(nll_pkg::op_e op, logic [31:0] frame,
                                           int lx, ly, lz, int r, g, b, int rad,
                                           int rx, ry, rz);
    light_item_t it;
    it.op = op;
    it.frame = frame;
    it.lx = nll_pkg::PosW'(lx);
    it.ly = nll_pkg::PosW'(ly);
    it.lz = nll_pkg::PosW'(lz);
    it.r = nll_pkg::ColW'(r);
    it.g = nll_pkg::ColW'(g);
    it.b = nll_pkg::ColW'(b);
    it.rad = nll_pkg::RadW'(rad);
    it.rx = nll_pkg::PosW'(rx);
    it.ry = nll_pkg::PosW'(ry);
    it.rz = nll_pkg::PosW'(rz);
    return it;
  endfunction

  function automatic logic signed [nll_pkg::PosW-1:0] pick_coord();
    case ($urandom_range(2))
      0: return nll_pkg::PosW'($urandom);
      1: return nll_pkg::PosW'($urandom_range(127) - 64);
      default: return nll_pkg::PosW'(16 * $urandom_range(3) - 24);
    endcase
  endfunction

  task automatic offer_light(input light_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    operation    = it.op;
    frame_number = it.frame;
    light_x      = it.lx;
    light_y      = it.ly;
    light_z      = it.lz;
    red          = it.r;
    green        = it.g;
    blue         = it.b;
    light_radius = it.rad;
    ref_x        = it.rx;
    ref_y        = it.ry;
    ref_z        = it.rz;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic next_light_item(output light_item_t it);
    int pick;
    pick = $urandom_range(99);
    it.op = (pick < 30) ? nll_pkg::OpAppend : (pick < 65) ? nll_pkg::OpInsert :
            (pick < 80) ? nll_pkg::OpRead : nll_pkg::OpClosest;
    it.lx = pick_coord();
    it.ly = pick_coord();
    it.lz = pick_coord();
    it.r = nll_pkg::ColW'($urandom);
    it.g = nll_pkg::ColW'($urandom);
    it.b = nll_pkg::ColW'($urandom);
    it.rad = nll_pkg::RadW'($urandom);
    if (it.op == nll_pkg::OpAppend || it.op == nll_pkg::OpInsert) begin
      pick = $urandom_range(99);
      if (pick < 7) begin
        cur_frame = cur_frame + $urandom_range(1, 4);
        cur_ref[0] = pick_coord();
        cur_ref[1] = pick_coord();
        cur_ref[2] = pick_coord();
      end
      it.frame = (pick >= 92) ? $urandom_range(cur_frame) : cur_frame;
    end else begin
      it.frame = $urandom;
    end
    if ($urandom_range(99) < 65) begin
      it.rx = cur_ref[0];
      it.ry = cur_ref[1];
      it.rz = cur_ref[2];
    end else begin
      it.rx = nll_pkg::PosW'($urandom);
      it.ry = nll_pkg::PosW'($urandom);
      it.rz = nll_pkg::PosW'($urandom);
    end
  endtask

  initial begin
    light_item_t it;
    int          waited;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    operation     = nll_pkg::OpAppend;
    frame_number  = '0;
    light_x       = '0;
    light_y       = '0;
    light_z       = '0;
    red           = '0;
    green         = '0;
    blue          = '0;
    light_radius  = '0;
    ref_x         = '0;
    ref_y         = '0;
    ref_z         = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req_cnt  = 0;
    cur_frame     = 32'd5;
    cur_ref       = '{default: '0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    offer_light(light_op(nll_pkg::OpRead, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpClosest, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpAppend, 0, -32768, 32767, 0, 255, 0, 255, 16'hFFFF,
                         0, 0, 0));
    offer_light(light_op(nll_pkg::OpAppend, 0, 32767, -32768, -1, 0, 255, 0, 0, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpAppend, 0, 0, 0, 0, 1, 2, 3, 16, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpAppend, 0, 100, 100, 100, 10, 20, 30, 160, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpInsert, 0, 0, 0, 0, 40, 50, 60, 32, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpAppend, 0, -16, 16, -16, 7, 7, 7, 8, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpAppend, 0, 4000, -4000, 0, 128, 64, 32, 1000, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpAppend, 0, 16, 16, 16, 170, 85, 170, 16'h5555,
                         0, 0, 0));
    // full list: append and a far insert both drop
    offer_light(light_op(nll_pkg::OpAppend, 0, 1, 2, 3, 9, 9, 9, 9, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpInsert, 0, -32768, -32768, -32768, 1, 1, 1, 1,
                         32767, 32767, 32767));
    offer_light(light_op(nll_pkg::OpInsert, 0, 5, 5, 5, 200, 100, 50, 77, 5, 5, 5));
    offer_light(light_op(nll_pkg::OpRead, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpClosest, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpClosest, 0, 0, 0, 0, 0, 0, 0, 0, 32767, 32767, 32767));
    offer_light(light_op(nll_pkg::OpAppend, 1, 48, 48, 48, 11, 22, 33, 44, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpInsert, 0, 8, 8, 8, 55, 66, 77, 88, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpInsert, 5, 8, 8, 8, 99, 88, 77, 66, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpInsert, 5, 80, 80, 80, 1, 2, 3, 4, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpInsert, 5, -8, 8, -8, 5, 6, 7, 8, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpRead, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpClosest, 0, 0, 0, 0, 0, 0, 0, 0, 8, -8, 8));

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_plan[phase];
      stall_pct = stall_plan[phase];
      if (phase == 0) begin
        in_valid = 1'b0;
        @(posedge clk);
        hold_req_cnt++;
        @(negedge clk);
      end
      repeat (31) begin
        next_light_item(it);
        offer_light(it);
      end
    end
    offer_light(light_op(nll_pkg::OpAppend, 32'hFFFF_FFFF, 3, 3, 3, 1, 1, 1, 1, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpInsert, 32'hFFFF_FFFF, 1, 1, 1, 2, 2, 2, 2, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpRead, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    offer_light(light_op(nll_pkg::OpClosest, 0, 0, 0, 0, 0, 0, 0, 0, 2, 2, 2));
    in_valid = 1'b0;

    waited = 0;
    while (pending != 0 && waited < 50_000) begin
      @(negedge clk);
      waited++;
    end
    if (pending != 0) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      repeat (80) @(negedge clk);
      if (errors == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
      $finish;
    end
  end

endmodule
